// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never occurs at any clock edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ple_pkg.sv -----
`timescale 1ns / 1ps

package ple_pkg;

    // Fixed field widths of the command and result transfers.
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int ENTRY_W = 32;
    localparam int CNT_W   = 7;
    localparam int ST_W    = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    // What every cell of the chain does.
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_INSERT = 2'd1,
        CM_REMOVE = 2'd2,
        CM_ROTATE = 2'd3
    } cell_mode_t;

    // Control broadcast to the whole chain.
    typedef struct packed {
        cell_mode_t       mode;
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] last_idx;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ple_cell.sv -----
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [ENTRY_W-1:0] left_data,
    input  logic [ENTRY_W-1:0] right_data,
    input  logic [ENTRY_W-1:0] head_data,
    input  logic [ENTRY_W-1:0] entry_in,
    output logic [ENTRY_W-1:0] data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;

    // Select the new content from the neighbors, the new entry or the head.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.mode)
            CM_HOLD:
            begin
                data_next = data_reg;
            end
            CM_INSERT:
            begin
                if (MY_IDX == ctrl.target)
                begin
                    data_next = entry_in;
                end
                else if (MY_IDX > ctrl.target)
                begin
                    data_next = left_data;
                end
            end
            CM_REMOVE:
            begin
                if (MY_IDX >= ctrl.target)
                begin
                    data_next = right_data;
                end
            end
            CM_ROTATE:
            begin
                if (MY_IDX == ctrl.last_idx)
                begin
                    data_next = head_data;
                end
                else if (MY_IDX < ctrl.last_idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/positional_list_engine_top.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of 32-bit handles held in a chain of cells, one
// entry per cell. Every insert or remove shifts the cells from the target
// slot on at once: start is taken when busy is low, and the single result
// appears on the next cycle with result_valid high for one cycle. A dump
// of a list keeps busy high until its last entry is registered while the
// chain rotates through the entries and ends in its original order; it emits
// one result per cycle, the first once the state register is in the dump
// state and the result registers hold the head cell. The receiver cannot
// stall: every result must be captured in the cycle in which result_valid is high.
// Errors (full, empty, bad position) leave the list unchanged.

`include "assert_macros.svh"

module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [POS_W-1:0]   position,
    input  logic [ENTRY_W-1:0] entry_in,
    output logic               result_valid,
    output logic [ENTRY_W-1:0] entry_out,
    output logic [POS_W-1:0]   slot_index,
    output logic [ST_W-1:0]    status,
    output logic [CNT_W-1:0]   entry_count,
    output logic               is_last
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic [ENTRY_W-1:0] eout_reg, eout_next;
    logic [POS_W-1:0]   sidx_reg, sidx_next;
    logic [ST_W-1:0]    st_reg, st_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    logic [ENTRY_W-1:0] cell_data [LIST_DEPTH];
    logic [ENTRY_W-1:0] sel_entry;
    logic [CNT_W-1:0]   target;
    logic [CNT_W-1:0]   count_m1;
    logic               accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign count_m1 = count_reg - CNT_W'(1);

    // Chain of cells; the ends see their own content as the missing neighbor.
    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            logic [ENTRY_W-1:0] left_d;
            logic [ENTRY_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = cell_data[g];
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end
            if (g == LIST_DEPTH - 1)
            begin : g_end
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end
            ple_cell #(
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .entry_in   (entry_in),
                .data       (cell_data[g])
            );
        end
    endgenerate

    // Target slot of the operation.
    always_comb
    begin
        target = {1'b0, position};
        unique case (op)
            OP_INS_FRONT, OP_REM_FRONT: target = '0;
            OP_INS_BACK:                target = count_reg;
            OP_REM_BACK:                target = count_m1;
            default:                    target = {1'b0, position};
        endcase
    end

    // Entry leaving the list on a remove.
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (CNT_W'(i) == target)
            begin
                sel_entry = sel_entry | cell_data[i];
            end
        end
    end

    // Sequencing of operations and dumps.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        valid_next    = 1'b0;
        eout_next     = '0;
        sidx_next     = '0;
        st_next       = ST_OK;
        last_next     = 1'b1;
        ctrl.mode     = CM_HOLD;
        ctrl.target   = target;
        ctrl.last_idx = count_m1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    valid_next = 1'b1;
                    unique case (op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (target > count_reg)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.mode  = CM_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REM_FRONT, OP_REM_BACK, OP_REM_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else if (target >= count_reg)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.mode  = CM_REMOVE;
                                eout_next  = sel_entry;
                                count_next = count_m1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                ctrl.mode  = CM_ROTATE;
                valid_next = 1'b1;
                eout_next  = cell_data[0];
                sidx_next  = idx_reg;
                last_next  = ({1'b0, idx_reg} == count_m1);
                idx_next   = idx_reg + POS_W'(1);
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        eout_reg <= eout_next;
        sidx_reg <= sidx_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    assign busy         = (state_reg == S_DUMP);
    assign result_valid = valid_reg;
    assign entry_out    = eout_reg;
    assign slot_index   = sidx_reg;
    assign status       = st_reg;
    assign entry_count  = count_reg;
    assign is_last      = last_reg;

    `ASSERT_NEVER(a_count_bound, count_reg > DEPTH_C, "entry count exceeds list depth")
    `ASSERT_CLK(a_single_result, accept && op != OP_DUMP |=> result_valid && is_last, "missing result after a single-result operation")
    `ASSERT_CLK(a_err_unchanged, result_valid && status != ST_OK |-> count_reg == $past(count_reg), "list changed on an error")
    `ASSERT_CLK(a_dump_emits, busy |=> result_valid, "dump cycle without a result")

endmodule
